### rtl/core/dedup_sort_param_list_assert.svh
// Assertion macros shared by the RTL of the sorted parameter list block.
`ifndef DEDUP_SORT_PARAM_LIST_ASSERT_SVH
`define DEDUP_SORT_PARAM_LIST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DSPL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSPL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/dspl_pkg.sv
package dspl_pkg;

   localparam int VALUE_W      = 16;
   localparam int LIST_SIZE_DEF = 8;

endpackage

### rtl/core/dspl_if.sv
// Input channel: one list entry per beat.
interface dspl_req_if;
   logic                           valid;
   logic                           ready;
   logic [dspl_pkg::VALUE_W-1:0]   item_value;
   logic                           item_last;

   modport source (output valid, output item_value, output item_last, input ready);
   modport sink   (input valid, input item_value, input item_last, output ready);
endinterface

// Result channel: one sorted value per beat.
interface dspl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dspl_pkg::VALUE_W-1:0]   sorted_value;
   logic                           sorted_last;
   logic                           overflowed;

   modport source (output valid, output sorted_value, output sorted_last,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input sorted_last,
                   input overflowed, output ready);
endinterface

### rtl/core/dedup_sort_param_list.sv
// Channel   Dir  Payload                                  Handshake
// req_bus   in   item_value[15:0], item_last              valid/ready
// rsp_bus   out  sorted_value[15:0], sorted_last, overflowed   valid/ready
//
// Loading: one entry beat per cycle into a LIST_SIZE-word memory, registered read.
// Each distinct result needs a scan of the n stored entries (one read each, then
// a settle state) plus its rsp beat; zero padding then goes one beat a cycle
// while rsp ready is high. The registered read port is why each scan ends in settle.
// Sync active-high reset clears count, overflow, found and read-valid flags and FSM, not the memory.
// req_ready is low from the last entry to the final result beat; rsp stalls hold.
module dedup_sort_param_list #(
   parameter int LIST_SIZE = dspl_pkg::LIST_SIZE_DEF
) (
   input  logic           clock,
   input  logic           reset,
   dspl_req_if.sink       req_bus,
   dspl_rsp_if.source     rsp_bus
);

   `include "dedup_sort_param_list_assert.svh"

   localparam int VW = dspl_pkg::VALUE_W;
   localparam int CW = $clog2(LIST_SIZE + 1);
   localparam int AW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_SETTLE = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] emit_cnt_ff, emit_cnt_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic          rd_vld_ff;
   logic [VW-1:0] rd_data_ff;
   logic [VW-1:0] prev_ff, prev_in;   // last value emitted, search floor
   logic [VW-1:0] best_ff, best_in;   // smallest value above prev seen so far
   logic          found_ff, found_in;

   logic [VW-1:0] entry_mem [LIST_SIZE];

   logic          req_acc, rsp_acc, mem_wr, has_room, is_last_rsp;
   logic [CW-1:0] count_m1;
   logic [AW-1:0] last_addr;

   assign has_room    = (count_ff < CW'(LIST_SIZE));
   assign req_acc     = req_bus.valid && req_bus.ready;
   assign rsp_acc     = rsp_bus.valid && rsp_bus.ready;
   assign mem_wr      = req_acc && has_room;
   assign count_m1    = count_ff - CW'(1);
   assign last_addr   = count_m1[AW-1:0];
   assign is_last_rsp = (emit_cnt_ff == count_m1);

   assign req_bus.ready        = (state_ff == ST_LOAD);
   assign rsp_bus.valid        = (state_ff == ST_EMIT);
   assign rsp_bus.sorted_value = found_ff ? best_ff : '0;
   assign rsp_bus.sorted_last  = is_last_rsp;
   assign rsp_bus.overflowed   = ovf_ff;

   // entry memory: write on load, one registered read per scan cycle
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         entry_mem[count_ff[AW-1:0]] <= req_bus.item_value;
      end
      rd_data_ff <= entry_mem[rd_addr_ff];
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      emit_cnt_in = emit_cnt_ff;
      rd_addr_in  = rd_addr_ff;
      prev_in     = prev_ff;
      best_in     = best_ff;
      found_in    = found_ff;

      // fold in the word read last cycle
      if (rd_vld_ff && (rd_data_ff > prev_ff) && (!found_ff || (rd_data_ff < best_ff))) begin
         best_in  = rd_data_ff;
         found_in = 1'b1;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (has_room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_bus.item_last) begin
                  state_in    = ST_SCAN;
                  emit_cnt_in = '0;
                  rd_addr_in  = '0;
                  prev_in     = '0;    // zero is never above the floor
                  found_in    = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_addr_ff == last_addr) begin
               state_in = ST_SETTLE;
            end else begin
               rd_addr_in = rd_addr_ff + AW'(1);
            end
         end
         ST_SETTLE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               emit_cnt_in = emit_cnt_ff + CW'(1);
               if (is_last_rsp) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else if (found_ff) begin
                  // search for the next distinct value
                  state_in   = ST_SCAN;
                  prev_in    = best_ff;
                  found_in   = 1'b0;
                  rd_addr_in = '0;
               end
               // not found: stay here and pad with zeros
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         rd_vld_ff <= (state_ff == ST_SCAN);
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_cnt_ff <= emit_cnt_in;
      rd_addr_ff  <= rd_addr_in;
      prev_ff     <= prev_in;
      best_ff     <= best_in;
   end

   `DSPL_ASSERT_NOW(a_no_overlap, clock, reset, rsp_bus.valid, !req_bus.ready,
                    "result offered while entries are still being loaded")
   `DSPL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(LIST_SIZE),
                    "entry count beyond list capacity")
   `DSPL_ASSERT_NEXT(a_list_clear, clock, reset, rsp_acc && rsp_bus.sorted_last,
                     (count_ff == '0) && !ovf_ff && req_bus.ready,
                     "list state not cleared after final result")
   `DSPL_ASSERT_NOW(a_ascending, clock, reset, rsp_bus.valid && found_ff,
                    best_ff > prev_ff, "result not above previous value")

endmodule

### verif/testbench.sv
module testbench;

   localparam int VALUE_W    = dspl_pkg::VALUE_W;
   localparam int LIST_CAP   = dspl_pkg::LIST_SIZE_DEF;
   // No beat on either channel for this many cycles means the block hung.
   // The slowest legal stretch is a full list scan plus the longest ready
   // stall, so this leaves a wide margin.
   localparam int HANG_LIMIT = 3000;
   // Cycles to sit after the last result: covers one full list scan.
   localparam int DRAIN_WAIT = 100;

   // Value styles
   localparam int STYLE_POOL = 0;   // tiny pool so duplicates pile up
   localparam int STYLE_FULL = 1;   // full 16-bit range
   localparam int STYLE_EDGE = 2;   // mix with zeros and edge values

   // Tracks the list being loaded and holds the sorted results it must
   // produce, in order.
   class sorted_list_tracker;
      typedef struct {
         logic [VALUE_W-1:0] value;
         bit                 last;
         bit                 ovf;
      } sorted_beat_type;

      logic [VALUE_W-1:0] entries[LIST_CAP];
      int unsigned        stored;
      bit                 dropped;
      sorted_beat_type    expected_sorted[$];

      int unsigned mismatches;
      int unsigned entries_in;
      int unsigned results_checked;
      int unsigned lists_done;
      int unsigned overflow_lists;

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH @%0t: %s", $time, what);
      endfunction

      // Accepted entry beat: store or drop it; on the last one, build the
      // ascending distinct nonzero values and pad with zeros.
      function void note_entry(logic [VALUE_W-1:0] value, bit last);
         logic [VALUE_W-1:0] uniq[$];
         sorted_beat_type    beat;
         int                 pos;
         entries_in++;
         if (stored < LIST_CAP) begin
            entries[stored] = value;
            stored++;
         end else begin
            dropped = 1'b1;
         end
         if (!last)
            return;
         for (int k = 0; k < stored; k++) begin
            if (entries[k] != '0) begin
               pos = 0;
               while (pos < uniq.size() && uniq[pos] < entries[k])
                  pos++;
               if (pos == uniq.size() || uniq[pos] != entries[k])
                  uniq.insert(pos, entries[k]);
            end
         end
         for (int k = 0; k < stored; k++) begin
            beat.value = (k < uniq.size()) ? uniq[k] : '0;
            beat.last  = (k == stored - 1);
            beat.ovf   = dropped;
            expected_sorted.push_back(beat);
         end
         lists_done++;
         if (dropped)
            overflow_lists++;
         stored  = 0;
         dropped = 1'b0;
      endfunction

      function void check_result(logic [VALUE_W-1:0] value, bit last, bit ovf);
         sorted_beat_type exp_beat;
         results_checked++;
         if (expected_sorted.size() == 0) begin
            flag($sformatf("unexpected result value=%h last=%b ovf=%b", value, last, ovf));
            return;
         end
         exp_beat = expected_sorted.pop_front();
         if (value !== exp_beat.value || last !== exp_beat.last || ovf !== exp_beat.ovf)
            flag($sformatf("exp value=%h last=%b ovf=%b, got value=%h last=%b ovf=%b",
                           exp_beat.value, exp_beat.last, exp_beat.ovf, value, last, ovf));
      endfunction
   endclass

   logic clock;
   logic reset;

   dspl_req_if req_bus();
   dspl_rsp_if rsp_bus();

   dedup_sort_param_list dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sorted_list_tracker board;

   // Idle modes, switched per list: calm means no gaps / no stalls.
   bit req_calm;
   bit rsp_calm;
   // Gap to insert before the next entry beat; valid is already low if > 0.
   int next_gap;
   int hang_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int pick_gap(bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(int style);
      int r;
      r = $urandom_range(0, 99);
      case (style)
         STYLE_POOL: begin
            return (r < 15) ? '0 : VALUE_W'($urandom_range(1, 6));
         end
         STYLE_FULL: begin
            return VALUE_W'($urandom);
         end
         default: begin
            if (r < 20)
               return '0;
            if (r < 28)
               return '1;
            if (r < 34)
               return VALUE_W'(1);
            if (r < 40)
               return VALUE_W'(16'h8000);
            return VALUE_W'($urandom);
         end
      endcase
   endfunction

   // One list, one entry beat per element, last flag on the final one.
   // Valid drops right after a beat when a gap follows, so a held valid
   // never gets lowered and raised in the same step. A list always ends
   // with a gap; the block holds ready low then anyway.
   task automatic send_list(input logic [VALUE_W-1:0] vals[$]);
      bit is_last;
      for (int k = 0; k < vals.size(); k++) begin
         is_last = (k == vals.size() - 1);
         if (next_gap > 0)
            repeat (next_gap) @(posedge clock);
         req_bus.valid      <= 1'b1;
         req_bus.item_value <= vals[k];
         req_bus.item_last  <= is_last;
         do @(posedge clock); while (!req_bus.ready);
         board.note_entry(vals[k], is_last);
         next_gap = pick_gap(req_calm);
         if (is_last && next_gap == 0)
            next_gap = 1;
         if (next_gap > 0)
            req_bus.valid <= 1'b0;
      end
   endtask

   // Sender holds off until every predicted result has come out.
   task automatic wait_drained();
      while (board.expected_sorted.size() != 0)
         @(posedge clock);
   endtask

   // Result side: random ready stalls, check every accepted beat.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_result(rsp_bus.sorted_value, rsp_bus.sorted_last,
                               rsp_bus.overflowed);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(rsp_calm);
         end
         @(posedge clock);
      end
   end

   // Watchdog: resets on any beat in either direction.
   initial begin
      hang_count = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            hang_count = 0;
         else
            hang_count++;
         if (hang_count >= HANG_LIMIT) begin
            $display("TIMEOUT: no beat for %0d cycles, %0d results outstanding",
                     HANG_LIMIT, board.expected_sorted.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [VALUE_W-1:0] list_vals[$];
      int                 rand_items;
      int                 len;
      int                 r;
      int                 style;

      board    = new();
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      next_gap = 0;
      rand_items = 0;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.item_value <= '0;
      req_bus.item_last  <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lists
      // single entry at the top of the range
      list_vals = '{16'hFFFF};
      send_list(list_vals);
      // single empty slot
      list_vals = '{16'h0000};
      send_list(list_vals);
      // duplicates, a zero and unsorted order
      list_vals = '{16'd5, 16'd3, 16'd5, 16'd0, 16'd1};
      send_list(list_vals);
      // all slots empty: every result is zero
      list_vals = '{16'h0000, 16'h0000, 16'h0000};
      send_list(list_vals);
      // overflow: two beyond capacity, the last-marked one among the dropped
      list_vals = '{16'hFFFF, 16'h8000, 16'h4000, 16'h0100, 16'h00FF,
                    16'h0010, 16'h0002, 16'h0001, 16'h7FFF, 16'h1234};
      send_list(list_vals);
      // hold the sender until all of that is out
      wait_drained();

      // Random lists: mostly up to capacity, some exactly full, some over.
      while (rand_items < 215) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         style    = $urandom_range(STYLE_POOL, STYLE_EDGE);
         r = $urandom_range(0, 99);
         if (r < 80)
            len = $urandom_range(1, LIST_CAP);
         else if (r < 92)
            len = LIST_CAP;
         else
            len = $urandom_range(LIST_CAP + 1, LIST_CAP + 4);
         list_vals.delete();
         repeat (len)
            list_vals.push_back(pick_value(style));
         send_list(list_vals);
         rand_items += len;
         if ($urandom_range(0, 7) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.expected_sorted.size() != 0)
         board.flag($sformatf("%0d results never arrived", board.expected_sorted.size()));

      $display("Run: %0d lists (%0d overflowed), %0d entry beats in", board.lists_done,
               board.overflow_lists, board.entries_in);
      $display("Run: %0d sorted result beats checked, %0d mismatches", board.results_checked,
               board.mismatches);
      if (board.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
